/* src/srpc_pkg.sv */
// Package for the stepper ramp and pause controller.
// Holds the item structs, state enums and fixed constants; depends on nothing.
package srpc_pkg;

  localparam int ADC_BITS        = 10;
  localparam int SCALE_FRAC_BITS = 16;
  localparam int SCALE_W         = SCALE_FRAC_BITS + 1;
  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << SCALE_FRAC_BITS;
  localparam logic [SCALE_W-1:0] SCALE_MIN =
    SCALE_W'(((1 << SCALE_FRAC_BITS) + 9999) / 10000);

  localparam int CFG_DW = 20;
  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_ADC_LO = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_ADC_HI = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_SLOW   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_FAST   = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_RAMP   = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_DIR    = 3'd5;

  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_START = 3'd1;
  localparam logic [2:0] REQ_STOP  = 3'd2;
  localparam logic [2:0] REQ_FLIP  = 3'd3;
  localparam logic [2:0] REQ_PAUSE = 3'd4;

  localparam int DIV_W = 48;
  localparam int DVS_W = 32;

  typedef enum logic [2:0] {
    K_TICK, K_START, K_STOP, K_FLIP, K_PAUSE, K_NOP
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_PAUSE = 2'd0, ST_UP = 2'd1, ST_RUN = 2'd2, ST_DOWN = 2'd3
  } mstate_t;

  typedef enum logic [3:0] {
    B_IDLE, B_CMD, B_CLAMP, B_BASE, B_BASE_WAIT, B_SCALE, B_T_WAIT,
    B_SQ, B_CUBE, B_IV, B_IV_WAIT, B_DONE
  } bstate_t;

  typedef struct packed {
    logic [2:0]          req_type;
    logic [ADC_BITS-1:0] adc_value;
    logic [31:0]         now_ms;
    logic [31:0]         now_us;
    logic [31:0]         pause_ms;
  } in_item_t;

  typedef struct packed {
    logic               step_pulse;
    logic               direction;
    logic [1:0]         motor_state;
    logic [SCALE_W-1:0] speed_scale;
    logic [31:0]        interval_us;
  } out_item_t;

  typedef struct packed {
    req_kind_t           kind;
    logic [ADC_BITS-1:0] adc;
    logic [31:0]         now_ms;
    logic [31:0]         now_us;
    logic [31:0]         pause_ms;
  } work_t;

  typedef struct packed {
    mstate_t     st;
    logic        dir;
    logic        flip;
    logic [31:0] npl;
    logic [31:0] start;
    logic [31:0] deadline;
  } ctl_t;

endpackage

/* src/srpc_fifo.sv */
// Short register queue between the front and back parts.
// Generic payload width and depth; no package dependency.
module srpc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rd_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* src/srpc_front.sv */
// Front part: accepts input items, classifies the request code and queues them.
// Depends on srpc_pkg and srpc_fifo.
module srpc_front
  import srpc_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_item,
  input  logic     q_pop,
  output logic     q_empty,
  output work_t    q_item
);
  work_t     w;
  req_kind_t kind;
  logic [$bits(work_t)-1:0] rd_bits;

  always_comb begin
    unique case (in_item.req_type)
      REQ_TICK:  kind = K_TICK;
      REQ_START: kind = K_START;
      REQ_STOP:  kind = K_STOP;
      REQ_FLIP:  kind = K_FLIP;
      REQ_PAUSE: kind = K_PAUSE;
      default:   kind = K_NOP;
    endcase
    w.kind     = kind;
    w.adc      = in_item.adc_value;
    w.now_ms   = in_item.now_ms;
    w.now_us   = in_item.now_us;
    w.pause_ms = in_item.pause_ms;
  end

  srpc_fifo #(.WIDTH($bits(work_t)), .DEPTH(DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (w),
    .full    (in_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (rd_bits)
  );

  assign q_item = work_t'(rd_bits);

endmodule

/* src/srpc_div.sv */
// Restoring divider, one quotient bit per cycle, shared by the back part.
// Depends on srpc_pkg for the operand widths.
module srpc_div
  import srpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);
  localparam int NW = $clog2(DIV_W);

  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [NW-1:0]    cnt_r, cnt_nxt;
  logic [DVS_W:0]   rem_r, rem_nxt, sh;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    sh       = {rem_r[DVS_W-1:0], quo_r[DIV_W-1]};
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (sh >= {1'b0, dvs_r}) begin
        rem_nxt = sh - {1'b0, dvs_r};
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = NW'(cnt_r + 1'b1);
      if (cnt_r == NW'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule

/* src/srpc_back.sv */
// Back part: motor state machine, speed map, ramp and step timing, result register.
// Depends on srpc_pkg and srpc_div.
module srpc_back
  import srpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              q_empty,
  output logic              q_pop,
  input  work_t             q_item,
  output logic              out_empty,
  input  logic              out_pop,
  output out_item_t         out_item
);
  function automatic ctl_t enter_f(ctl_t c, mstate_t st, logic [31:0] now,
                                   logic [15:0] ramp);
    ctl_t r;
    r       = c;
    r.st    = st;
    r.start = now;
    unique case (st)
      ST_PAUSE: begin
        if (r.flip) begin
          r.dir  = ~r.dir;
          r.flip = 1'b0;
        end
        r.deadline = (r.npl != 32'd0) ? now + r.npl : 32'd0;
        r.npl      = 32'd0;
      end
      ST_RUN: begin
        r.deadline = 32'd0;
        r.npl      = 32'd0;
      end
      ST_UP, ST_DOWN: begin
        r.deadline = now + {16'd0, ramp};
      end
    endcase
    return r;
  endfunction

  bstate_t bst_r, bst_nxt;
  ctl_t    ctl_r, ctl_nxt, c;
  work_t   it_r, it_nxt;

  logic [ADC_BITS-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [19:0]         slow_r, slow_nxt, fast_r, fast_nxt;
  logic [15:0]         ramp_r, ramp_nxt;

  logic [29:0]        prod_r, prod_nxt;
  logic [30:0]        base_r, base_nxt;
  logic [SCALE_W-1:0] t_r, t_nxt, t2_r, t2_nxt, scale_r, scale_nxt;
  logic [31:0]        ival_r, ival_nxt, last_us_r, last_us_nxt;
  logic               pulse_r, pulse_nxt;
  out_item_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic             div_start, div_busy, div_done;
  logic [DIV_W-1:0] div_dvd, div_q;
  logic [DVS_W-1:0] div_dvs;

  logic [ADC_BITS-1:0] adc_c;
  logic [19:0]         diff;
  logic [30:0]         term;
  logic [31:0]         span, el;
  logic [33:0]         sq;
  logic [18:0]         fac;
  logic [35:0]         cu;
  logic [19:0]         s_raw;
  logic [SCALE_W-1:0]  s_cl, d;

  srpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    bst_nxt       = bst_r;
    ctl_nxt       = ctl_r;
    it_nxt        = it_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    slow_nxt      = slow_r;
    fast_nxt      = fast_r;
    ramp_nxt      = ramp_r;
    prod_nxt      = prod_r;
    base_nxt      = base_r;
    t_nxt         = t_r;
    t2_nxt        = t2_r;
    scale_nxt     = scale_r;
    ival_nxt      = ival_r;
    last_us_nxt   = last_us_r;
    pulse_nxt     = pulse_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_pop;
    q_pop         = 1'b0;
    div_start     = 1'b0;
    div_dvd       = '0;
    div_dvs       = '0;
    c             = ctl_r;
    adc_c         = it_r.adc;
    diff          = '0;
    term          = div_q[30:0];
    span          = ctl_r.deadline - ctl_r.start;
    el            = it_r.now_ms - ctl_r.start;
    sq            = t_r * t_r;
    fac           = 19'(3 << SCALE_FRAC_BITS) - {1'b0, t_r, 1'b0};
    cu            = t2_r * fac;
    s_raw         = cu[35:16];
    s_cl          = (s_raw > 20'(SCALE_ONE)) ? SCALE_ONE : s_raw[SCALE_W-1:0];
    d             = (scale_r < SCALE_MIN) ? SCALE_MIN : scale_r;

    unique case (bst_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          it_nxt  = q_item;
          bst_nxt = (q_item.kind == K_TICK) ? B_CLAMP : B_CMD;
        end
      end
      B_CMD: begin
        unique case (it_r.kind)
          K_START: begin
            c.npl = 32'd0;
            if (c.st != ST_RUN && c.st != ST_UP) begin
              c = enter_f(c, ST_UP, it_r.now_ms, ramp_r);
            end
          end
          K_STOP: begin
            c.flip = 1'b0;
            c.npl  = 32'd0;
            if (c.st == ST_PAUSE) begin
              c = enter_f(c, ST_PAUSE, it_r.now_ms, ramp_r);
            end else if (c.st != ST_DOWN) begin
              c = enter_f(c, ST_DOWN, it_r.now_ms, ramp_r);
            end
          end
          K_FLIP: begin
            c.flip = 1'b1;
            c.npl  = 32'd1;
            c = enter_f(c, (c.st == ST_PAUSE) ? ST_PAUSE : ST_DOWN, it_r.now_ms, ramp_r);
          end
          K_PAUSE: begin
            if (c.st != ST_PAUSE && c.st != ST_DOWN) begin
              c.npl = it_r.pause_ms;
              c = enter_f(c, ST_DOWN, it_r.now_ms, ramp_r);
            end
          end
          default: begin
          end
        endcase
        ctl_nxt   = c;
        pulse_nxt = 1'b0;
        scale_nxt = '0;
        ival_nxt  = '0;
        bst_nxt   = B_DONE;
      end
      B_CLAMP: begin
        // Low is tested first: with lo above hi, values below lo get lo, all others hi.
        if (it_r.adc < lo_r) begin
          adc_c = lo_r;
        end else if (it_r.adc > hi_r) begin
          adc_c = hi_r;
        end
        diff     = (slow_r >= fast_r) ? slow_r - fast_r : fast_r - slow_r;
        prod_nxt = adc_c * diff;
        if (ctl_r.deadline != 32'd0 && it_r.now_ms >= ctl_r.deadline) begin
          ctl_nxt = enter_f(ctl_r, mstate_t'(2'(ctl_r.st + 2'd1)), it_r.now_ms, ramp_r);
        end
        bst_nxt = B_BASE;
      end
      B_BASE: begin
        if (hi_r == '0) begin
          base_nxt = {11'd0, slow_r};
          bst_nxt  = B_SCALE;
        end else begin
          div_start = 1'b1;
          div_dvd   = DIV_W'(prod_r);
          div_dvs   = DVS_W'(hi_r);
          bst_nxt   = B_BASE_WAIT;
        end
      end
      B_BASE_WAIT: begin
        // With the low bound above the high one the map term can exceed the span.
        if (div_done) begin
          if (slow_r >= fast_r) begin
            base_nxt = (term >= {11'd0, slow_r}) ? 31'd0 : {11'd0, slow_r} - term;
          end else begin
            base_nxt = {11'd0, slow_r} + term;
          end
          bst_nxt = B_SCALE;
        end
      end
      B_SCALE: begin
        unique case (ctl_r.st)
          ST_PAUSE: begin
            scale_nxt   = '0;
            ival_nxt    = 32'(base_r);
            last_us_nxt = it_r.now_us;
            pulse_nxt   = 1'b0;
            bst_nxt     = B_DONE;
          end
          ST_RUN: begin
            scale_nxt = SCALE_ONE;
            bst_nxt   = B_IV;
          end
          ST_UP, ST_DOWN: begin
            if (span == 32'd0 || el >= span) begin
              t_nxt   = SCALE_ONE;
              bst_nxt = B_SQ;
            end else begin
              div_start = 1'b1;
              div_dvd   = {el, {SCALE_FRAC_BITS{1'b0}}};
              div_dvs   = span;
              bst_nxt   = B_T_WAIT;
            end
          end
        endcase
      end
      B_T_WAIT: begin
        if (div_done) begin
          t_nxt   = div_q[SCALE_W-1:0];
          bst_nxt = B_SQ;
        end
      end
      B_SQ: begin
        t2_nxt  = sq[SCALE_FRAC_BITS +: SCALE_W];
        bst_nxt = B_CUBE;
      end
      B_CUBE: begin
        scale_nxt = (ctl_r.st == ST_DOWN) ? SCALE_ONE - s_cl : s_cl;
        bst_nxt   = B_IV;
      end
      B_IV: begin
        div_start = 1'b1;
        div_dvd   = (DIV_W'(base_r) << SCALE_FRAC_BITS) + DIV_W'(d) - DIV_W'(1);
        div_dvs   = DVS_W'(d);
        bst_nxt   = B_IV_WAIT;
      end
      B_IV_WAIT: begin
        if (div_done) begin
          ival_nxt  = (|div_q[DIV_W-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];
          pulse_nxt = 1'b0;
          if ((it_r.now_us - last_us_r) >= ival_nxt) begin
            pulse_nxt   = 1'b1;
            last_us_nxt = it_r.now_us;
          end
          bst_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid_r || out_pop) begin
          out_nxt.step_pulse  = pulse_r;
          out_nxt.direction   = ctl_r.dir;
          out_nxt.motor_state = ctl_r.st;
          out_nxt.speed_scale = scale_r;
          out_nxt.interval_us = ival_r;
          out_valid_nxt       = 1'b1;
          bst_nxt             = B_IDLE;
        end
      end
      default: bst_nxt = B_IDLE;
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ADC_LO: lo_nxt   = cfg_data[ADC_BITS-1:0];
        CFG_ADC_HI: hi_nxt   = cfg_data[ADC_BITS-1:0];
        CFG_SLOW:   slow_nxt = cfg_data[19:0];
        CFG_FAST:   fast_nxt = cfg_data[19:0];
        CFG_RAMP:   ramp_nxt = cfg_data[15:0];
        CFG_DIR:    ctl_nxt.dir = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r       <= B_IDLE;
      ctl_r       <= '{st: ST_PAUSE, dir: 1'b0, flip: 1'b0, npl: 32'd0,
                       start: 32'd0, deadline: 32'd0};
      lo_r        <= '0;
      hi_r        <= ADC_BITS'(1023);
      slow_r      <= 20'd2000;
      fast_r      <= 20'd200;
      ramp_r      <= 16'd500;
      last_us_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bst_r       <= bst_nxt;
      ctl_r       <= ctl_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      slow_r      <= slow_nxt;
      fast_r      <= fast_nxt;
      ramp_r      <= ramp_nxt;
      last_us_r   <= last_us_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r    <= it_nxt;
    prod_r  <= prod_nxt;
    base_r  <= base_nxt;
    t_r     <= t_nxt;
    t2_r    <= t2_nxt;
    scale_r <= scale_nxt;
    ival_r  <= ival_nxt;
    pulse_r <= pulse_nxt;
    out_r   <= out_nxt;
  end

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider started while busy");
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    (bst_r == B_IDLE) |-> !div_busy) else $error("divider busy in idle");
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(bst_r) == B_DONE) else $error("result not from done");
  a_scale_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.speed_scale <= SCALE_ONE) else $error("scale above one");

endmodule

/* src/stepper_ramp_pause_controller.sv */
// Stepper ramp and pause controller, top level.
// A command item passes the command and done states from queue to result register.
// A tick uses the shared 48-step divider for the speed map, the ramp fraction and
// the step interval, up to three times, then passes the done state.
// One item is worked on at a time; a QUEUE_DEPTH queue absorbs arrivals.
// Synchronous active-low reset: motor paused, no deadline, registers at defaults.
module stepper_ramp_pause_controller
  import srpc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  in_item_t          in_item,
  output logic              out_empty,
  input  logic              out_pop,
  output out_item_t         out_item,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);
  logic  q_pop, q_empty;
  work_t q_item;

  srpc_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_item  (q_item)
  );

  srpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
